/* rtl/ltd_pkg.sv */
// Shared types, constants and fixed-point helpers of the Lanczos tridiagonalizer.
package ltd_pkg;

  localparam int MAX_DIM   = 32;
  localparam int FRAC_BITS = 24;
  localparam int IDX_W     = $clog2(MAX_DIM);
  localparam int N_W       = IDX_W + 1;
  localparam int DIV_W     = 32 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;

  localparam logic [1:0] CMD_MATRIX = 2'd0;
  localparam logic [1:0] CMD_VECTOR = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BREAK = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  localparam logic [1:0] REG_DIMENSION = 2'd0;
  localparam logic [1:0] REG_STEPS     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [4:0]         index;
    logic signed [31:0] diag;
    logic signed [31:0] offdiag;
    logic [1:0]         status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic signed [31:0] sv;
    logic signed [31:0] cur;
    logic signed [31:0] prev;
    logic signed [31:0] res;
    logic signed [31:0] wp;
  } cell_data_t;

  typedef struct packed {
    logic               load_sv;
    logic [IDX_W-1:0]   row;
    logic signed [31:0] value;
    logic               shift_main;
    logic               shift_wp;
  } cell_ctrl_t;

  function automatic logic signed [63:0] qround(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] r;
    neg = p[63];
    mag = neg ? 64'(-p) : 64'(p);
    r = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

endpackage

/* rtl/lanczos_tridiagonalizer_top.sv */
// Top level of the Lanczos tridiagonalizer: command decode, sequencer and vector chain.
// Busy stays low for matrix and start vector writes.
// A run first normalizes the start vector, then per step forms the matrix-vector
// product through the single multiplier and the matrix memory read port, then alpha,
// the residual, its norm and the divider-bound normalization; steps after a
// breakdown only report the breakdown status.
// The vectors live in a rotating chain of 32 cells that always makes full turns.
// Results appear for one cycle on result with result_valid and cannot be held off.
module lanczos_tridiagonalizer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ltd_pkg::item_t   item,
  output logic             result_valid,
  output ltd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import ltd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_NRM  = 9'b000000010,
    S_SQRT = 9'b000000100,
    S_NML  = 9'b000001000,
    S_MV   = 9'b000010000,
    S_DOT  = 9'b000100000,
    S_RES  = 9'b001000000,
    S_NRMR = 9'b010000000,
    S_BRK  = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] sub;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] irow;
  logic [4:0] j;
  logic [N_W-1:0] n_reg;
  logic [N_W-1:0] m_reg;
  logic [5:0] dim_cfg;
  logic [5:0] steps_cfg;
  logic [30:0] thr_cfg;
  logic first;
  logic signed [63:0] p;
  logic signed [63:0] acc;
  logic signed [63:0] r1;
  logic [63:0] sumsq;
  logic signed [31:0] alpha;
  logic signed [31:0] pc;
  logic [30:0] dsr;
  logic signed [31:0] mrd;
  logic signed [31:0] mem [MEM_DEPTH];

  cell_data_t cd [MAX_DIM];
  cell_data_t head;
  cell_data_t tail;
  cell_ctrl_t ctrl;

  logic accept;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] term;
  logic ok;
  logic signed [63:0] acc_next;
  logic [64:0] sq_sum;
  logic pass_end;
  logic last_j;
  logic [N_W-1:0] n_new;
  logic [N_W-1:0] m_new;

  logic sq_start;
  logic sq_done;
  logic [31:0] sq_root;
  logic [30:0] root_sat;
  logic div_start;
  logic div_done;
  logic [DIV_W-1:0] div_quo;
  logic signed [31:0] src;
  logic [31:0] src_mag;
  logic [DIV_W-1:0] dividend;
  logic signed [31:0] qv;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign head     = cd[0];
  assign ok       = {1'b0, ptr} < n_reg;
  assign term     = qround(p);
  assign acc_next = acc + (ok ? term : 64'sd0);
  assign sq_sum   = {1'b0, sumsq} + {1'b0, (ok ? p : 64'sd0)};
  assign pass_end = ctrl.shift_main && ptr == IDX_W'(MAX_DIM - 1);
  assign last_j   = {1'b0, j} == m_reg - 1'b1;
  assign root_sat = sq_root[31] ? 31'h7FFF_FFFF : sq_root[30:0];

  assign n_new = (dim_cfg == '0) ? N_W'(1)
               : (N_W'(dim_cfg) > N_W'(MAX_DIM)) ? N_W'(MAX_DIM) : N_W'(dim_cfg);
  assign m_new = (steps_cfg == '0) ? N_W'(1)
               : (N_W'(steps_cfg) > n_new || steps_cfg > 6'(MAX_DIM)) ? n_new
               : N_W'(steps_cfg);

  assign src      = first ? head.sv : head.res;
  assign src_mag  = src[31] ? 32'(-src) : 32'(src);
  assign dividend = {src_mag, {FRAC_BITS{1'b0}}} + DIV_W'(dsr >> 1);
  always_comb begin
    logic [31:0] qs;
    qs = (div_quo > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quo[31:0];
    qv = src[31] ? -$signed(qs) : $signed(qs);
  end

  assign sq_start  = (state == S_SQRT) && sub == 2'd0;
  assign div_start = (state == S_NML) && sub == 2'd0;

  ltd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(sumsq), .done(sq_done), .root(sq_root)
  );

  ltd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend), .divisor(dsr),
    .done(div_done), .quo(div_quo)
  );

  always_comb begin
    mul_a = head.cur;
    mul_b = head.cur;
    unique case (state)
      S_NRM: begin
        mul_a = head.sv;
        mul_b = head.sv;
      end
      S_NRMR: begin
        mul_a = head.res;
        mul_b = head.res;
      end
      S_MV: begin
        mul_a = mrd;
      end
      S_DOT: begin
        mul_a = head.wp;
      end
      S_RES: begin
        if (sub == 2'd0) begin
          mul_a = alpha;
        end else begin
          mul_a = pc;
          mul_b = head.prev;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tail            = head;
    ctrl.load_sv    = accept && item.cmd == CMD_VECTOR;
    ctrl.row        = item.row;
    ctrl.value      = item.value;
    ctrl.shift_main = 1'b0;
    ctrl.shift_wp   = 1'b0;
    unique case (state)
      S_NRM, S_NRMR, S_DOT: begin
        if (sub == 2'd1) begin
          ctrl.shift_main = 1'b1;
          ctrl.shift_wp   = 1'b1;
        end
      end
      S_NML: begin
        if (sub == 2'd1 && div_done) begin
          ctrl.shift_main = 1'b1;
          ctrl.shift_wp   = 1'b1;
          tail.cur  = ok ? qv : 32'sd0;
          tail.prev = first ? 32'sd0 : head.cur;
          tail.res  = first ? 32'sd0 : head.res;
        end
      end
      S_MV: begin
        if (sub == 2'd2) begin
          ctrl.shift_main = 1'b1;
          if (ptr == IDX_W'(MAX_DIM - 1)) begin
            ctrl.shift_wp = 1'b1;
            tail.wp = sat32(acc_next);
          end
        end
      end
      S_RES: begin
        if (sub == 2'd2) begin
          ctrl.shift_main = 1'b1;
          ctrl.shift_wp   = 1'b1;
          tail.res = ok ? sat32(64'(head.wp) - r1 - term) : 32'sd0;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
    cell_data_t nb;
    if (g == MAX_DIM - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = cd[g + 1];
    end
    ltd_cell u_cell (
      .clk(clk), .ctrl(ctrl), .idx(IDX_W'(g)), .nb(nb), .q(cd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && item.cmd == CMD_MATRIX) begin
      mem[{item.row, item.col}] <= item.value;
    end
    mrd <= mem[{irow, ptr}];
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (rst) begin
      state        <= S_IDLE;
      sub          <= '0;
      ptr          <= '0;
      irow         <= '0;
      j            <= '0;
      result_valid <= 1'b0;
      dim_cfg      <= 6'd32;
      steps_cfg    <= 6'd32;
      thr_cfg      <= 31'd1;
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DIMENSION: dim_cfg   <= cfg_data[5:0];
          REG_STEPS:     steps_cfg <= cfg_data[5:0];
          REG_THRESHOLD: thr_cfg   <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      if (ctrl.shift_main) begin
        ptr <= ptr + 1'b1;
        sub <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.cmd == CMD_RUN) begin
            n_reg <= n_new;
            m_reg <= m_new;
            sumsq <= '0;
            first <= 1'b1;
            sub   <= '0;
            state <= S_NRM;
          end
        end
        S_NRM, S_NRMR: begin
          if (sub == 2'd1) begin
            sumsq <= sq_sum[64] ? '1 : sq_sum[63:0];
            if (pass_end) begin
              state <= S_SQRT;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_SQRT: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else if (sq_done) begin
            sub <= '0;
            if (first) begin
              if (root_sat == '0) begin
                result_valid <= 1'b1;
                result <= '{index: '0, diag: '0, offdiag: '0, status: ST_ZERO, last: 1'b1};
                state <= S_IDLE;
              end else begin
                dsr   <= root_sat;
                state <= S_NML;
              end
            end else begin
              pc <= $signed({1'b0, root_sat});
              if (root_sat <= thr_cfg) begin
                j     <= j + 1'b1;
                state <= S_BRK;
              end else begin
                dsr   <= root_sat;
                state <= S_NML;
              end
            end
          end
        end
        S_NML: begin
          if (sub == 2'd0) begin
            sub <= 2'd1;
          end else if (pass_end) begin
            if (first) begin
              j  <= '0;
              pc <= '0;
            end else begin
              j <= j + 1'b1;
            end
            first <= 1'b0;
            irow  <= '0;
            acc   <= '0;
            state <= S_MV;
          end
        end
        S_MV: begin
          if (sub == 2'd2) begin
            if (pass_end) begin
              acc  <= '0;
              irow <= irow + 1'b1;
              if (irow == IDX_W'(MAX_DIM - 1)) begin
                state <= S_DOT;
              end
            end else begin
              acc <= acc_next;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_DOT: begin
          if (sub == 2'd1) begin
            if (pass_end) begin
              acc          <= '0;
              alpha        <= sat32(acc_next);
              result_valid <= 1'b1;
              result <= '{index: j, diag: sat32(acc_next), offdiag: pc,
                          status: ST_OK, last: last_j};
              state <= last_j ? S_IDLE : S_RES;
            end else begin
              acc <= acc_next;
            end
          end else begin
            sub <= sub + 1'b1;
          end
        end
        S_RES: begin
          if (sub == 2'd1) begin
            r1 <= term;
          end
          if (sub != 2'd2) begin
            sub <= sub + 1'b1;
          end else if (pass_end) begin
            sumsq <= '0;
            state <= S_NRMR;
          end
        end
        S_BRK: begin
          result_valid <= 1'b1;
          result <= '{index: j, diag: '0, offdiag: '0, status: ST_BREAK, last: last_j};
          if (last_j) begin
            state <= S_IDLE;
          end else begin
            j <= j + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_zero_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_ZERO |-> result.last)
    else $error("zero start vector result is not the last one");
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && item.cmd == CMD_RUN |=> busy)
    else $error("run command did not make the block busy");
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("block went idle before the final result");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ctrl.shift_main)
    else $error("vector chain moved while idle");
`endif

endmodule

/* rtl/ltd_cell.sv */
// One cell of the vector chain: one entry of every working vector.
module ltd_cell (
  input  logic                      clk,
  input  ltd_pkg::cell_ctrl_t       ctrl,
  input  logic [ltd_pkg::IDX_W-1:0] idx,
  input  ltd_pkg::cell_data_t       nb,
  output ltd_pkg::cell_data_t       q
);
  import ltd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load_sv && ctrl.row == idx) begin
      q.sv <= ctrl.value;
    end else if (ctrl.shift_main) begin
      q.sv <= nb.sv;
    end
    if (ctrl.shift_main) begin
      q.cur  <= nb.cur;
      q.prev <= nb.prev;
      q.res  <= nb.res;
    end
    if (ctrl.shift_wp) begin
      q.wp <= nb.wp;
    end
  end

endmodule

/* rtl/ltd_sqrt.sv */
// Iterative floor square root of a 64-bit value, one result bit per cycle.
module ltd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);
  import ltd_pkg::*;

  logic        run;
  logic [63:0] xr;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = res + bitv;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && bitv == 64'd1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      xr   <= x;
      res  <= '0;
      bitv <= 64'd1 << 62;
    end else if (run) begin
      if (xr >= trial) begin
        xr  <= xr - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

/* rtl/ltd_div.sv */
// Restoring divider for normalization, one quotient bit per cycle.
module ltd_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ltd_pkg::DIV_W-1:0] dividend,
  input  logic [30:0]               divisor,
  output logic                      done,
  output logic [ltd_pkg::DIV_W-1:0] quo
);
  import ltd_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     dvd;
  logic [30:0]          rem;
  logic [31:0]          rem_sh;
  logic                 fits;

  assign rem_sh = {rem, dvd[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      quo <= '0;
      cnt <= DIV_CNT_W'(DIV_W - 1);
    end else if (run) begin
      rem <= fits ? 31'(rem_sh - {1'b0, divisor}) : rem_sh[30:0];
      quo <= {quo[DIV_W-2:0], fits};
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the Lanczos tridiagonalizer, with a scoreboard that predicts each run.
module testbench;
  import ltd_pkg::*;

  typedef int signed vec_t [MAX_DIM];

  class lanczos_scoreboard;
    int signed   mat [MAX_DIM][MAX_DIM];
    vec_t        start_vec;
    logic [5:0]  dim_reg = 6'd32;
    logic [5:0]  steps_reg = 6'd32;
    logic [30:0] thresh_reg = 31'd1;
    result_t     expected_steps [$];
    int          errors = 0;

    function void set_register(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_DIMENSION: dim_reg = data[5:0];
        REG_STEPS:     steps_reg = data[5:0];
        REG_THRESHOLD: thresh_reg = data[30:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint fxmul(int signed a, int signed b);
      longint p;
      logic [63:0] mag;
      p = longint'(a) * longint'(b);
      mag = (p < 0) ? -p : p;
      mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (p < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function logic [63:0] norm_of(vec_t v, int n);
      logic [63:0] sum, sq, mag, x, root, bitv;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        mag = (v[i] < 0) ? -longint'(v[i]) : longint'(v[i]);
        sq = mag * mag;
        sum = (sum > ~sq) ? ~64'd0 : sum + sq;
      end
      x = sum;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x = x - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return (root > 64'd2147483647) ? 64'd2147483647 : root;
    endfunction

    function void scale(output vec_t dst, input vec_t src, input int n, input logic [63:0] d);
      logic [63:0] mag, q;
      for (int i = 0; i < MAX_DIM; i++) dst[i] = 0;
      for (int i = 0; i < n; i++) begin
        mag = (src[i] < 0) ? -longint'(src[i]) : longint'(src[i]);
        q = ((mag << FRAC_BITS) + d / 2) / d;
        if (q > 64'd2147483647) q = 64'd2147483647;
        dst[i] = (src[i] < 0) ? -int'(q) : int'(q);
      end
    endfunction

    function void predict_run();
      int n, m;
      vec_t cur, prev, resid, wp;
      logic [63:0] nrm, beta;
      longint acc;
      int signed alpha, coupling;
      bit broken;
      result_t r;
      n = int'(dim_reg);
      if (n < 1) n = 1;
      if (n > MAX_DIM) n = MAX_DIM;
      m = int'(steps_reg);
      if (m < 1) m = 1;
      if (m > n) m = n;
      for (int i = 0; i < MAX_DIM; i++) prev[i] = 0;
      coupling = 0;
      broken = 0;
      nrm = norm_of(start_vec, n);
      if (nrm == 0) begin
        r = '{index: 0, diag: 0, offdiag: 0, status: ST_ZERO, last: 1'b1};
        expected_steps.push_back(r);
        return;
      end
      scale(cur, start_vec, n, nrm);
      for (int j = 0; j < m; j++) begin
        r.index = 5'(j);
        r.last = (j == m - 1);
        if (broken) begin
          r.diag = 0;
          r.offdiag = 0;
          r.status = ST_BREAK;
          expected_steps.push_back(r);
          continue;
        end
        for (int i = 0; i < n; i++) begin
          acc = 0;
          for (int k = 0; k < n; k++) acc += fxmul(mat[i][k], cur[k]);
          wp[i] = int'(sat(acc));
        end
        acc = 0;
        for (int i = 0; i < n; i++) acc += fxmul(wp[i], cur[i]);
        alpha = int'(sat(acc));
        r.diag = alpha;
        r.offdiag = coupling;
        r.status = ST_OK;
        expected_steps.push_back(r);
        if (r.last) break;
        for (int i = 0; i < MAX_DIM; i++) resid[i] = 0;
        for (int i = 0; i < n; i++)
          resid[i] = int'(sat(longint'(wp[i]) - fxmul(alpha, cur[i])
                              - fxmul(coupling, prev[i])));
        beta = norm_of(resid, n);
        coupling = int'(beta);
        if (beta <= {33'd0, thresh_reg}) begin
          broken = 1;
        end else begin
          prev = cur;
          scale(cur, resid, n, beta);
        end
      end
    endfunction

    function void note_item(item_t it);
      case (it.cmd)
        CMD_MATRIX: mat[it.row][it.col] = it.value;
        CMD_VECTOR: start_vec[it.row] = it.value;
        CMD_RUN:    predict_run();
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_steps.size() == 0) begin
        $error("unexpected result: index %0d diag %0d", got.index, got.diag);
        errors++;
        return;
      end
      want = expected_steps.pop_front();
      if (got.index !== want.index) begin
        $error("index: expected %0d, actual %0d", want.index, got.index);
        errors++;
      end
      if (got.diag !== want.diag) begin
        $error("diag: expected %0d, actual %0d", want.diag, got.diag);
        errors++;
      end
      if (got.offdiag !== want.offdiag) begin
        $error("offdiag: expected %0d, actual %0d", want.offdiag, got.offdiag);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  item_t      item;
  logic       result_valid;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  lanczos_scoreboard sb;
  bit mat_written [MAX_DIM][MAX_DIM];
  bit vec_written [MAX_DIM];
  int cur_dim = 32;
  int sent = 0;

  lanczos_tridiagonalizer_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_result(result);
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function int signed pick_value();
    if ($urandom_range(0, 9) == 0) return int'($urandom);
    return int'($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
  endfunction

  task automatic send(logic [1:0] cmd, logic [4:0] row, logic [4:0] col, int signed value);
    int gap;
    start <= 1'b1;
    item <= '{cmd: cmd, row: row, col: col, value: value};
    do @(posedge clk); while (busy);
    sb.note_item(item_t'{cmd: cmd, row: row, col: col, value: value});
    if (cmd == CMD_MATRIX) mat_written[row][col] = 1;
    if (cmd == CMD_VECTOR) vec_written[row] = 1;
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_steps.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_register(idx, data);
    if (idx == REG_DIMENSION) begin
      cur_dim = int'(data[5:0]);
      if (cur_dim < 1) cur_dim = 1;
      if (cur_dim > MAX_DIM) cur_dim = MAX_DIM;
    end
  endtask

  task automatic configure(logic [31:0] dim, logic [31:0] steps, logic [31:0] thresh);
    wait_idle();
    write_reg(REG_DIMENSION, dim);
    write_reg(REG_STEPS, steps);
    write_reg(REG_THRESHOLD, thresh);
  endtask

  task automatic sym_write(int i, int k, int signed v);
    send(CMD_MATRIX, 5'(i), 5'(k), v);
    if (i != k) send(CMD_MATRIX, 5'(k), 5'(i), v);
  endtask

  task automatic load_missing();
    for (int i = 0; i < cur_dim; i++) begin
      if (!vec_written[i]) send(CMD_VECTOR, 5'(i), 5'($urandom), pick_value());
      for (int k = 0; k <= i; k++)
        if (!mat_written[i][k] || !mat_written[k][i]) sym_write(i, k, pick_value());
    end
  endtask

  task automatic run_now();
    load_missing();
    send(CMD_RUN, 5'($urandom), 5'($urandom), int'($urandom));
  endtask

  initial begin
    logic [31:0] dim, steps, thresh;
    int r;
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(4, 4, 1);
    sym_write(0, 0, 32'sh7FFF_FFFF);
    sym_write(1, 2, 32'sh8000_0000);
    send(CMD_NONE, 5'd31, 5'd31, 32'sh7FFF_FFFF);
    run_now();
    for (int i = 0; i < 4; i++) send(CMD_VECTOR, 5'(i), 5'd0, 0);
    run_now();
    sym_write(0, 0, 32'sh0100_0000);
    send(CMD_VECTOR, 5'd0, 5'd0, 32'sh0100_0000);
    configure(4, 32, 32'h7FFF_FFFF);
    run_now();
    configure(1, 1, 0);
    send(CMD_VECTOR, 5'd0, 5'd31, 32'sh8000_0000);
    run_now();
    configure(32'h0000_0046, 0, 32'hFFFF_FFFF);
    run_now();
    configure(0, 63, 32'h0000_0001);
    run_now();

    while (sent < 300) begin
      if ($urandom_range(0, 2) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 80) dim = $urandom_range(1, 6);
        else if (r < 90) dim = $urandom_range(7, 10);
        else if (r < 95) dim = 0;
        else dim = 32'($urandom_range(1, 3)) * 64 + 32'($urandom_range(1, 6));
        r = $urandom_range(0, 99);
        if (r < 60) steps = 1;
        else if (r < 80) steps = 2;
        else if (r < 95) steps = ($urandom_range(0, 1)) ? 32 : 63;
        else steps = 0;
        r = $urandom_range(0, 3);
        thresh = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? $urandom_range(0, 32'h0400_0000)
               : $urandom;
        if (steps > 2) thresh = 32'h7FFF_FFFF;
        configure(dim, steps, thresh);
      end
      repeat ($urandom_range(0, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 60) sym_write($urandom_range(0, cur_dim - 1), $urandom_range(0, cur_dim - 1),
                              pick_value());
        else if (r < 85) send(CMD_VECTOR, 5'($urandom), 5'($urandom), pick_value());
        else if (r < 90) send(CMD_NONE, 5'($urandom), 5'($urandom), int'($urandom));
        else send(CMD_MATRIX, 5'($urandom), 5'($urandom), pick_value());
      end
      run_now();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_steps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* lanczos_tridiagonalizer_top.f */
rtl/ltd_pkg.sv
rtl/ltd_cell.sv
rtl/ltd_sqrt.sv
rtl/ltd_div.sv
rtl/lanczos_tridiagonalizer_top.sv
sim/testbench.sv
